[sv/pnp_rtp_pkg.sv]
// Package for the resource-data tag parser: byte classes, phase codes,
// stop reasons and tag constants. No dependencies.
package pnp_rtp_pkg;

    localparam int unsigned HEADER_BYTES = 9;

    // byte classes reported per transfer
    localparam logic [3:0] CLS_HEADER  = 4'd0;
    localparam logic [3:0] CLS_TAG     = 4'd1;
    localparam logic [3:0] CLS_LENLO   = 4'd2;
    localparam logic [3:0] CLS_LENHI   = 4'd3;
    localparam logic [3:0] CLS_STRING  = 4'd4;
    localparam logic [3:0] CLS_DEVID   = 4'd5;
    localparam logic [3:0] CLS_SKIP    = 4'd6;
    localparam logic [3:0] CLS_ENDPAY  = 4'd7;
    localparam logic [3:0] CLS_IGNORED = 4'd8;

    // parser phases
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_TAG     = 4'd1;
    localparam logic [3:0] PH_LENLO   = 4'd2;
    localparam logic [3:0] PH_LENHI   = 4'd3;
    localparam logic [3:0] PH_STRING  = 4'd4;
    localparam logic [3:0] PH_DEVID   = 4'd5;
    localparam logic [3:0] PH_SKIP    = 4'd6;
    localparam logic [3:0] PH_ENDPAY  = 4'd7;
    localparam logic [3:0] PH_STOPPED = 4'd8;

    // stop reasons
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_BAD_HDR = 2'd1;
    localparam logic [1:0] STOP_BAD_TAG = 2'd2;
    localparam logic [1:0] STOP_END_TAG = 2'd3;

    localparam logic [6:0] TYPE_STRING = 7'h02;
    localparam logic [3:0] TYPE_DEVID  = 4'h2;
    localparam logic [3:0] TYPE_END    = 4'hf;
    localparam int unsigned DEVID_BYTES = 4;

    localparam logic [7:0] ASCII_NUL = 8'h00;
    localparam logic [7:0] ASCII_CR  = 8'h0d;
    localparam logic [7:0] ASCII_LF  = 8'h0a;
    localparam logic [7:0] BYTE_ONES = 8'hff;

endpackage

[sv/pnp_resource_tag_parser.sv]
// Each accepted input byte is classified into the output result register.
// Throughput: one byte per cycle while the result side is not stalled; the parser state
// updates on each input transfer and the result register takes the next byte while a result is taken in the same cycle.
// Reset (i_rst_n low, synchronous) returns the parser to the header phase and
// empties the result register. i_new_card restarts parsing in any phase.
// Resource-data byte classifier, single stage. Depends on pnp_rtp_pkg.
module pnp_resource_tag_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_card,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_byte_class,
    output logic       o_printable,
    output logic [6:0] o_resource_type,
    output logic       o_is_large,
    output logic [1:0] o_id_index,
    output logic [1:0] o_stop_reason,
    output logic       o_done_res
);
    import pnp_rtp_pkg::*;

    localparam logic [3:0] HDR_LAST = 4'(HEADER_BYTES);

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  hdr_count;
        logic        hdr_zero;
        logic        hdr_ones;
        logic [15:0] rem_len;
        logic [6:0]  cur_type;
        logic        large_flag;
        logic [2:0]  id_count;
        logic [1:0]  reason;
    } t_state;

    localparam t_state ST_RESET = '{
        phase: PH_HEADER, hdr_count: 4'd0, hdr_zero: 1'b1, hdr_ones: 1'b1,
        rem_len: 16'd0, cur_type: 7'd0, large_flag: 1'b0, id_count: 3'd0,
        reason: STOP_NONE};

    t_state     r_st, n_st, w_cur;
    logic       r_out_valid;
    logic [3:0] r_class, n_class;
    logic       r_prn, n_prn;
    logic [1:0] r_idx, n_idx;
    logic       w_take;
    logic [15:0] w_dec;
    logic [2:0]  w_len;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        w_cur   = i_new_card ? ST_RESET : r_st;
        n_st    = w_cur;
        n_class = CLS_IGNORED;
        n_prn   = 1'b0;
        n_idx   = 2'd0;
        w_dec   = w_cur.rem_len - 16'd1;
        w_len   = i_data_byte[2:0];
        case (w_cur.phase)
            PH_HEADER: begin
                n_class = CLS_HEADER;
                if (i_data_byte != 8'h00) n_st.hdr_zero = 1'b0;
                if (i_data_byte != BYTE_ONES) n_st.hdr_ones = 1'b0;
                n_st.hdr_count = w_cur.hdr_count + 4'd1;
                if (n_st.hdr_count >= HDR_LAST) begin
                    if (n_st.hdr_zero || n_st.hdr_ones) begin
                        n_st.reason = STOP_BAD_HDR;
                        n_st.phase  = PH_STOPPED;
                    end else begin
                        n_st.phase = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                n_class = CLS_TAG;
                if (i_data_byte == 8'h00 || i_data_byte == BYTE_ONES) begin
                    n_st.reason = STOP_BAD_TAG;
                    n_st.phase  = PH_STOPPED;
                end else if (i_data_byte[7]) begin
                    n_st.large_flag = 1'b1;
                    n_st.cur_type   = i_data_byte[6:0];
                    n_st.rem_len    = 16'd0;
                    n_st.phase      = PH_LENLO;
                end else begin
                    n_st.large_flag = 1'b0;
                    n_st.cur_type   = {3'd0, i_data_byte[6:3]};
                    if (i_data_byte[6:3] == TYPE_DEVID && w_len >= 3'(DEVID_BYTES)) begin
                        n_st.rem_len  = {13'd0, w_len - 3'(DEVID_BYTES)};
                        n_st.id_count = 3'd0;
                        n_st.phase    = PH_DEVID;
                    end else if (i_data_byte[6:3] == TYPE_END) begin
                        // empty end tag still consumes one byte
                        n_st.rem_len = (w_len == 3'd0) ? 16'd1 : {13'd0, w_len};
                        n_st.phase   = PH_ENDPAY;
                    end else begin
                        n_st.rem_len = {13'd0, w_len};
                        n_st.phase   = (w_len != 3'd0) ? PH_SKIP : PH_TAG;
                    end
                end
            end
            PH_LENLO: begin
                n_class      = CLS_LENLO;
                n_st.rem_len = {8'd0, i_data_byte};
                n_st.phase   = PH_LENHI;
            end
            PH_LENHI: begin
                n_class      = CLS_LENHI;
                n_st.rem_len = {i_data_byte, w_cur.rem_len[7:0]};
                if (n_st.rem_len == 16'd0) begin
                    n_st.phase = PH_TAG;
                end else begin
                    n_st.phase = (w_cur.cur_type == TYPE_STRING) ? PH_STRING : PH_SKIP;
                end
            end
            PH_STRING: begin
                n_class = CLS_STRING;
                n_prn   = (i_data_byte != ASCII_NUL) && (i_data_byte != ASCII_CR)
                          && (i_data_byte != ASCII_LF);
                n_st.rem_len = w_dec;
                if (w_dec == 16'd0) n_st.phase = PH_TAG;
            end
            PH_DEVID: begin
                n_class       = CLS_DEVID;
                n_idx         = w_cur.id_count[1:0];
                n_st.id_count = w_cur.id_count + 3'd1;
                if (n_st.id_count >= 3'(DEVID_BYTES)) begin
                    n_st.phase = (w_cur.rem_len != 16'd0) ? PH_SKIP : PH_TAG;
                end
            end
            PH_SKIP: begin
                n_class      = CLS_SKIP;
                n_st.rem_len = w_dec;
                if (w_dec == 16'd0) n_st.phase = PH_TAG;
            end
            PH_ENDPAY: begin
                n_class      = CLS_ENDPAY;
                n_st.rem_len = w_dec;
                if (w_dec == 16'd0) begin
                    n_st.reason = STOP_END_TAG;
                    n_st.phase  = PH_STOPPED;
                end
            end
            default: begin
                n_class = CLS_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; resource fields are read back from the parser state
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_class <= n_class;
            r_prn   <= n_prn;
            r_idx   <= n_idx;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_class    = r_class;
    assign o_printable     = r_prn;
    assign o_id_index      = r_idx;
    assign o_resource_type = r_st.cur_type;
    assign o_is_large      = r_st.large_flag;
    assign o_stop_reason   = r_st.reason;
    assign o_done_res      = (r_st.phase >= PH_STOPPED);

    a_prn_only_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_prn |-> r_class == CLS_STRING)
        else $error("printable set on a non-string byte");

    a_idx_only_devid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_idx != 2'd0) |-> r_class == CLS_DEVID)
        else $error("device id index set on a non-id byte");

    a_done_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase >= PH_STOPPED) == (r_st.reason != STOP_NONE))
        else $error("stop reason and stopped phase disagree");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase <= PH_STOPPED)
        else $error("parser phase out of range");

    a_restart_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_new_card |=> r_class == CLS_HEADER && r_st.reason == STOP_NONE)
        else $error("new card did not restart in header phase");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for pnp_resource_tag_parser: a directed stimulus table plus random card
// images, every result checked against a local parser model or a typed table row. Needs pnp_rtp_pkg.
module tb_top;
    import pnp_rtp_pkg::*;

    localparam int ITEMS          = 1350;
    localparam int CALM_TAIL      = 150;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PLAN_ROWS      = 31;

    typedef struct packed {
        logic [3:0] byte_class;
        logic       printable;
        logic [6:0] resource_type;
        logic       is_large;
        logic [1:0] id_index;
        logic [1:0] stop_reason;
        logic       done;
    } t_tag_result;

    typedef struct packed {
        logic [7:0]  data;
        logic        restart;
        logic        typed;
        t_tag_result want;
    } t_byte_item;

    localparam t_tag_result HDR_START = '{CLS_HEADER, 1'b0, 7'd0, 1'b0, 2'd0, STOP_NONE, 1'b0};
    localparam t_tag_result END_DONE =
        '{CLS_ENDPAY, 1'b0, {3'b000, TYPE_END}, 1'b0, 2'd0, STOP_END_TAG, 1'b1};
    localparam t_tag_result IGNORED_AFTER_END =
        '{CLS_IGNORED, 1'b0, {3'b000, TYPE_END}, 1'b0, 2'd0, STOP_END_TAG, 1'b1};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_new_card = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_byte_class;
    logic       o_printable;
    logic [6:0] o_resource_type;
    logic       o_is_large;
    logic [1:0] o_id_index;
    logic [1:0] o_stop_reason;
    logic       o_done_res;

    pnp_resource_tag_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_new_card      (i_new_card),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_class    (o_byte_class),
        .o_printable     (o_printable),
        .o_resource_type (o_resource_type),
        .o_is_large      (o_is_large),
        .o_id_index      (o_id_index),
        .o_stop_reason   (o_stop_reason),
        .o_done_res      (o_done_res)
    );

    always #5 i_clk = ~i_clk;

    // parser model state
    logic [3:0]  ph;
    logic [3:0]  hdr_cnt;
    logic        hdr_zero;
    logic        hdr_ones;
    logic [15:0] left_len;
    logic [6:0]  cur_type;
    logic        cur_large;
    logic [2:0]  id_cnt;
    logic [1:0]  why_stopped;

    t_byte_item  offered_bytes[$];
    t_tag_result pending_classes[$];
    t_byte_item  card_bytes[$];
    int unsigned parsed_bytes = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    wire         calm = (parsed_bytes >= ITEMS - CALM_TAIL);

    t_byte_item plan [PLAN_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, HDR_START},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, HDR_START},
        '{8'h82, 1'b0, 1'b0, '0},   // large string tag, length 4
        '{8'h04, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},   // NUL, LF, CR are not printable
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h0D, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},   // large tag with zero length
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h15, 1'b0, 1'b0, '0},   // device ID, length 5: four IDs, one skipped
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'hAB, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},   // small tags with zero length
        '{8'h10, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},   // empty end tag still eats one byte
        '{8'h00, 1'b0, 1'b1, END_DONE},
        '{8'hFF, 1'b0, 1'b1, IGNORED_AFTER_END},
        '{8'h5A, 1'b1, 1'b1, HDR_START}
    };

    function automatic void clear_parser();
        ph          = PH_HEADER;
        hdr_cnt     = 4'd0;
        hdr_zero    = 1'b1;
        hdr_ones    = 1'b1;
        left_len    = 16'd0;
        cur_type    = 7'd0;
        cur_large   = 1'b0;
        id_cnt      = 3'd0;
        why_stopped = STOP_NONE;
    endfunction

    function automatic void halt(input logic [1:0] reason);
        why_stopped = reason;
        ph          = PH_STOPPED;
    endfunction

    function automatic void count_down();
        left_len = left_len - 16'd1;
        if (left_len == 16'd0) ph = PH_TAG;
    endfunction

    function automatic t_tag_result classify_byte(input logic [7:0] b, input logic restart);
        t_tag_result r;
        logic [2:0]  len;
        r = '0;
        r.byte_class = CLS_IGNORED;
        len = b[2:0];
        if (restart) clear_parser();
        case (ph)
            PH_HEADER: begin
                r.byte_class = CLS_HEADER;
                if (b != ASCII_NUL) hdr_zero = 1'b0;
                if (b != BYTE_ONES) hdr_ones = 1'b0;
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= 4'(HEADER_BYTES)) begin
                    if (hdr_zero || hdr_ones) halt(STOP_BAD_HDR);
                    else ph = PH_TAG;
                end
            end
            PH_TAG: begin
                r.byte_class = CLS_TAG;
                if (b == ASCII_NUL || b == BYTE_ONES) begin
                    halt(STOP_BAD_TAG);
                end else if (b[7]) begin
                    cur_large = 1'b1;
                    cur_type  = b[6:0];
                    left_len  = 16'd0;
                    ph        = PH_LENLO;
                end else begin
                    cur_large = 1'b0;
                    cur_type  = {3'b000, b[6:3]};
                    if (b[6:3] == TYPE_DEVID && len >= 3'd4) begin
                        left_len = {13'd0, len - 3'd4};
                        id_cnt   = 3'd0;
                        ph       = PH_DEVID;
                    end else if (b[6:3] == TYPE_END) begin
                        left_len = (len == 3'd0) ? 16'd1 : {13'd0, len};
                        ph       = PH_ENDPAY;
                    end else begin
                        left_len = {13'd0, len};
                        ph       = (len != 3'd0) ? PH_SKIP : PH_TAG;
                    end
                end
            end
            PH_LENLO: begin
                r.byte_class = CLS_LENLO;
                left_len     = {8'h00, b};
                ph           = PH_LENHI;
            end
            PH_LENHI: begin
                r.byte_class = CLS_LENHI;
                left_len     = {b, left_len[7:0]};
                if (left_len == 16'd0) ph = PH_TAG;
                else ph = (cur_type == TYPE_STRING) ? PH_STRING : PH_SKIP;
            end
            PH_STRING: begin
                r.byte_class = CLS_STRING;
                r.printable  = (b != ASCII_NUL && b != ASCII_CR && b != ASCII_LF);
                count_down();
            end
            PH_DEVID: begin
                r.byte_class = CLS_DEVID;
                r.id_index   = id_cnt[1:0];
                id_cnt       = id_cnt + 3'd1;
                if (id_cnt >= 3'(DEVID_BYTES)) ph = (left_len != 16'd0) ? PH_SKIP : PH_TAG;
            end
            PH_SKIP: begin
                r.byte_class = CLS_SKIP;
                count_down();
            end
            PH_ENDPAY: begin
                r.byte_class = CLS_ENDPAY;
                left_len     = left_len - 16'd1;
                if (left_len == 16'd0) halt(STOP_END_TAG);
            end
            default: r.byte_class = CLS_IGNORED;
        endcase
        r.resource_type = cur_type;
        r.is_large      = cur_large;
        r.stop_reason   = why_stopped;
        r.done          = (ph >= PH_STOPPED);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : class_compare
        t_tag_result calc;
        t_tag_result want;
        t_byte_item  item;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                item = offered_bytes.pop_front();
                calc = classify_byte(i_data_byte, i_new_card);
                if (calc.byte_class != CLS_IGNORED) parsed_bytes++;
                pending_classes.push_back(item.typed ? item.want : calc);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_classes.size() == 0) begin
                    $error("result transfer with no byte outstanding");
                    errors++;
                end else begin
                    want = pending_classes.pop_front();
                    check_field("byte_class", int'(want.byte_class), int'(o_byte_class));
                    check_field("printable", int'(want.printable), int'(o_printable));
                    check_field("resource_type", int'(want.resource_type),
                                int'(o_resource_type));
                    check_field("is_large", int'(want.is_large), int'(o_is_large));
                    check_field("id_index", int'(want.id_index), int'(o_id_index));
                    check_field("stop_reason", int'(want.stop_reason), int'(o_stop_reason));
                    check_field("done_res", int'(want.done), int'(o_done_res));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: short random stalls, one long hold-off that backs up the input
    initial begin : result_drain
        bit held;
        held = 1'b0;
        repeat (6) @(posedge i_clk);
        forever begin
            if (!held && parsed_bytes >= ITEMS / 3) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic offer(input t_byte_item item, input bit lazy);
        if (lazy && !calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        offered_bytes.push_back(item);
        i_in_valid  <= 1'b1;
        i_data_byte <= item.data;
        i_new_card  <= item.restart;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        card_bytes.push_back('{b, card_bytes.size() == 0, 1'b0, '0});
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 5))
            0: return ASCII_NUL;
            1: return BYTE_ONES;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] string_char();
        case ($urandom_range(0, 7))
            0: return ASCII_NUL;
            1: return ASCII_CR;
            2: return ASCII_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one card image: header, a few resources, end tag; some cards broken or bad
    task automatic build_card();
        int   pick;
        int   kind;
        int   len;
        int   t;
        card_bytes.delete();
        pick = $urandom_range(0, 19);
        for (int i = 0; i < HEADER_BYTES; i++)
            put_byte(pick == 0 ? ASCII_NUL : pick == 1 ? BYTE_ONES : any_byte());
        if (pick <= 2) begin
            // invalid header, or plain noise after a header
            repeat ($urandom_range(1, pick == 2 ? 30 : 3)) put_byte(any_byte());
            return;
        end
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    len = ($urandom_range(0, 24) == 0) ? $urandom_range(256, 300)
                                                       : $urandom_range(0, 12);
                    put_byte({1'b1, TYPE_STRING});
                    put_byte(len[7:0]);
                    put_byte(len[15:8]);
                    repeat (len) put_byte(string_char());
                end
                2: begin
                    len = $urandom_range(0, 10);
                    put_byte(8'h80 | 8'($urandom_range(0, 126)));
                    put_byte(len[7:0]);
                    put_byte(8'h00);
                    repeat (len) put_byte(any_byte());
                end
                3, 4: begin
                    len = $urandom_range(4, 7);
                    put_byte({1'b0, TYPE_DEVID, len[2:0]});
                    repeat (len) put_byte(any_byte());
                end
                5, 6, 7: begin
                    t   = $urandom_range(0, 14);
                    len = $urandom_range(t == 0 ? 1 : 0, 7);
                    put_byte({1'b0, t[3:0], len[2:0]});
                    repeat (len) put_byte(any_byte());
                end
                8: begin
                    put_byte($urandom_range(0, 1) ? BYTE_ONES : ASCII_NUL);
                    repeat ($urandom_range(1, 3)) put_byte(any_byte());
                    return;
                end
                default: begin
                    // cut off inside a resource; the next card restarts mid-parse
                    pick = $urandom_range(0, 2);
                    put_byte({1'b1, TYPE_STRING});
                    if (pick >= 1) put_byte(8'd6);
                    if (pick >= 2) begin
                        put_byte(8'h00);
                        repeat (2) put_byte(string_char());
                    end
                    return;
                end
            endcase
        end
        len = $urandom_range(0, 7);
        put_byte({1'b0, TYPE_END, len[2:0]});
        repeat (len == 0 ? 1 : len) put_byte(any_byte());
        repeat ($urandom_range(0, 2)) put_byte(any_byte());
    endtask

    initial begin : byte_source
        bit paused;
        bit lazy;
        paused = 1'b0;
        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) offer(plan[i], 1'b1);

        while (parsed_bytes < ITEMS) begin
            if (!paused && parsed_bytes >= ITEMS / 2) begin
                // let the pipeline run dry before carrying on
                paused = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_classes.size() != 0);
            end
            build_card();
            lazy = ($urandom_range(0, 2) != 0);
            foreach (card_bytes[i]) offer(card_bytes[i], lazy);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_classes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
sv/pnp_rtp_pkg.sv
sv/pnp_resource_tag_parser.sv
bench/tb_top.sv
